@@ rtl/core/lda_topic_gibbs_resampler_defines.svh @@
// Assertion macros shared by the resampler checker.
`ifndef LDA_TOPIC_GIBBS_RESAMPLER_DEFINES_SVH
`define LDA_TOPIC_GIBBS_RESAMPLER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define LDA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
// Implication with the consequent checked in the cycle after the antecedent.
`define LDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`endif

@@ rtl/core/lda_pkg.sv @@
// Shared types and constants of the topic resampler.
package lda_pkg;
   localparam int TOPICS_MAX_DEF = 64;
   localparam int WORDS_MAX_DEF  = 4096;
   localparam int CNT_W    = 12;
   localparam int PROB_W   = 16;
   localparam int ALPHA_W  = 16;
   localparam int UNI_W    = 16;
   localparam int NT_W     = 7;
   localparam int TOPIC_W  = 6;
   localparam int WORD_W   = 12;
   localparam int STATUS_W = 2;
   localparam logic [CNT_W-1:0] COUNT_MAX = 12'hFFF;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0, OP_CLEAR = 2'd1, OP_COUNT = 2'd2, OP_RESAMPLE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_UNDERFLOW = 2'd1, ST_SATURATED = 2'd2
   } status_type;

   localparam logic CSR_NUM_TOPICS = 1'b0;
   localparam logic CSR_ALPHA      = 1'b1;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;       // capture input item
      logic tbl_write;  // write table entry
      logic clr_step;   // clear count at scan index
      logic dec_rd;     // read old topic count
      logic dec_old;    // remove old topic
      logic acc_rd;     // issue table/count read for scan index
      logic acc_add;    // add product term and store running sum
      logic tgt_mul;    // target, low half product
      logic tgt_add;    // target, high half product and sum
      logic srch_rd;    // read running sum at scan index
      logic srch_cmp;   // compare read sum
      logic inc_rd;     // read count of picked topic (or the count opcode topic)
      logic inc_pick;   // count picked topic (or the count opcode topic)
      logic scan_clr;   // reset scan index
      logic scan_inc;   // advance scan index
      logic rsp_load;   // load response register
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   scan_last;  // scan index is last of the active range
      logic   scan_done;  // scan index is past the active range
      logic   scan_end;   // scan index is the last built topic
      logic   found;      // search has matched
   } sts_type;
endpackage

@@ rtl/core/lda_dpath.sv @@
// Datapath: table memory, counts, running sums, multiply-accumulate and search.
module lda_dpath import lda_pkg::*; #(
   parameter int TOPICS_MAX = TOPICS_MAX_DEF,
   parameter int WORDS_MAX  = WORDS_MAX_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [1:0]          in_op,
   input  logic [WORD_W-1:0]   in_word,
   input  logic [TOPIC_W-1:0]  in_topic,
   input  logic [PROB_W-1:0]   in_prob,
   input  logic [UNI_W-1:0]    in_uniform,
   input  logic [NT_W-1:0]     num_topics,
   input  logic [ALPHA_W-1:0]  alpha,
   output logic [TOPIC_W-1:0]  out_topic,
   output logic [STATUS_W-1:0] out_status
);
   localparam int TI_W   = $clog2(TOPICS_MAX);
   localparam int WI_W   = $clog2(WORDS_MAX);
   localparam int SC_W   = TI_W + 1;
   localparam int SUM_W  = 46;
   localparam int TRM_W  = CNT_W + 8 + 1 + PROB_W;
   localparam int HALF_W = SUM_W / 2;
   localparam int PL_W   = HALF_W + UNI_W;
   localparam int TGT_W  = SUM_W + UNI_W;

   logic [PROB_W-1:0] tbl_mem [WORDS_MAX*TOPICS_MAX];
   logic [CNT_W-1:0]  cnt_mem [TOPICS_MAX];
   logic [SUM_W-1:0]  sum_mem [TOPICS_MAX];

   logic [1:0]          op_ff;
   logic [WI_W-1:0]     word_ff;
   logic [TOPIC_W-1:0]  topic_ff;
   logic [TI_W-1:0]     t_ff;
   logic [PROB_W-1:0]   prob_ff;
   logic [UNI_W-1:0]    uni_ff;
   logic [SC_W-1:0]     scan_ff;
   logic [TI_W-1:0]     scan_d_ff;
   logic [PROB_W-1:0]   prob_rd_ff;
   logic [CNT_W-1:0]    cnt_rd_ff;
   logic [SUM_W-1:0]    total_ff;
   logic [PL_W-1:0]     prod_lo_ff;
   logic [SUM_W-1:0]    target_ff;
   logic [SUM_W-1:0]    sum_rd_ff;
   logic [TI_W-1:0]     pick_ff;
   logic                found_ff;
   logic                under_ff;
   logic [TOPIC_W-1:0]  out_topic_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [SC_W-1:0]     k_use;
   logic [TI_W-1:0]     scan_i;
   logic [TI_W-1:0]     inc_idx;
   logic [TRM_W-1:0]    term;
   logic [SUM_W-1:0]    total_in;
   logic [PL_W-1:0]     prod_hi;
   logic [TGT_W-1:0]    tgt_prod;
   logic                cnt_we;
   logic [TI_W-1:0]     cnt_wa;
   logic [CNT_W-1:0]    cnt_wd;
   logic                cnt_re;
   logic [TI_W-1:0]     cnt_ra;

   always_comb begin
      if (num_topics == '0)
         k_use = SC_W'(1);
      else if (32'(num_topics) > TOPICS_MAX)
         k_use = SC_W'(TOPICS_MAX);
      else
         k_use = SC_W'(num_topics);
   end

   assign scan_i   = scan_ff[TI_W-1:0];
   assign term     = TRM_W'((TRM_W'(cnt_rd_ff) << 8) + TRM_W'(alpha)) * TRM_W'(prob_rd_ff);
   assign total_in = total_ff + SUM_W'(term);
   // Target in two halves: total * uniform = (hi << HALF_W) + lo.
   assign prod_hi  = PL_W'(total_ff[SUM_W-1:HALF_W] * uni_ff);
   assign tgt_prod = (TGT_W'(prod_hi) << HALF_W) + TGT_W'(prod_lo_ff);
   assign inc_idx  = (op_ff == OP_RESAMPLE) ? pick_ff : t_ff;

   assign sts.op        = op_type'(op_ff);
   assign sts.scan_last = (scan_ff + SC_W'(1)) >= k_use;
   assign sts.scan_done = scan_ff >= k_use;
   assign sts.scan_end  = (scan_ff + SC_W'(1)) >= SC_W'(TOPICS_MAX);
   assign sts.found     = found_ff;
   assign out_topic     = out_topic_ff;
   assign out_status    = out_status_ff;

   // Count memory port selects: one write and one registered read a cycle.
   always_comb begin
      cnt_we = 1'b0;
      cnt_wa = scan_i;
      cnt_wd = '0;
      if (cmd.clr_step) begin
         cnt_we = 1'b1;
      end else if (cmd.dec_old) begin
         cnt_we = (cnt_rd_ff != '0);
         cnt_wa = t_ff;
         cnt_wd = cnt_rd_ff - CNT_W'(1);
      end else if (cmd.inc_pick) begin
         cnt_we = (cnt_rd_ff != COUNT_MAX);
         cnt_wa = inc_idx;
         cnt_wd = cnt_rd_ff + CNT_W'(1);
      end
   end

   assign cnt_re = cmd.acc_rd || cmd.dec_rd || cmd.inc_rd;
   assign cnt_ra = cmd.dec_rd ? t_ff : (cmd.inc_rd ? inc_idx : scan_i);

   // Count memory.
   always_ff @(posedge clock) begin
      if (cnt_we)
         cnt_mem[cnt_wa] <= cnt_wd;
      if (cnt_re)
         cnt_rd_ff <= cnt_mem[cnt_ra];
   end

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.tbl_write)
         tbl_mem[{word_ff, t_ff}] <= prob_ff;
      if (cmd.acc_rd)
         prob_rd_ff <= tbl_mem[{word_ff, scan_i}];
   end

   // Running sum memory.
   always_ff @(posedge clock) begin
      if (cmd.acc_add)
         sum_mem[scan_d_ff] <= total_in;
      if (cmd.srch_rd)
         sum_rd_ff <= sum_mem[scan_i];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= in_op;
         word_ff  <= WI_W'(in_word);
         topic_ff <= in_topic;
         t_ff     <= TI_W'(in_topic);
         prob_ff  <= in_prob;
         uni_ff   <= in_uniform;
      end
      if (cmd.acc_rd)
         scan_d_ff <= scan_i;
      if (cmd.scan_clr)
         total_ff <= '0;
      else if (cmd.acc_add)
         total_ff <= total_in;
      if (cmd.tgt_mul)
         prod_lo_ff <= PL_W'(total_ff[HALF_W-1:0] * uni_ff);
      if (cmd.tgt_add)
         target_ff <= SUM_W'(tgt_prod >> UNI_W);
      if (cmd.srch_rd)
         scan_d_ff <= scan_i;
      if (cmd.scan_clr)
         pick_ff <= '0;
      else if (cmd.srch_cmp && !found_ff && sum_rd_ff >= target_ff)
         pick_ff <= scan_d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff       <= '0;
         found_ff      <= 1'b0;
         under_ff      <= 1'b0;
         out_topic_ff  <= '0;
         out_status_ff <= ST_OK;
      end else begin
         if (cmd.scan_clr)
            scan_ff <= '0;
         else if (cmd.scan_inc)
            scan_ff <= scan_ff + SC_W'(1);
         if (cmd.scan_clr)
            found_ff <= 1'b0;
         else if (cmd.srch_cmp && sum_rd_ff >= target_ff)
            found_ff <= 1'b1;
         if (cmd.load)
            under_ff <= 1'b0;
         else if (cmd.dec_old && cnt_rd_ff == '0)
            under_ff <= 1'b1;
         if (cmd.rsp_load) begin
            out_topic_ff <= (op_ff == OP_RESAMPLE) ? TOPIC_W'(pick_ff) : topic_ff;
            if (op_ff == OP_RESAMPLE && under_ff)
               out_status_ff <= ST_UNDERFLOW;
            else if ((op_ff == OP_RESAMPLE || op_ff == OP_COUNT)
                     && cnt_rd_ff == COUNT_MAX)
               out_status_ff <= ST_SATURATED;
            else
               out_status_ff <= ST_OK;
         end
      end
   end
endmodule

@@ rtl/core/lda_ctrl.sv @@
// Controller: sequences each item through the datapath.
module lda_ctrl import lda_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd,
   input  sts_type sts
);
   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_DISPATCH, S_CLEAR, S_DEC_RD, S_DEC, S_ACC_RD, S_ACC_LAST,
      S_TGT, S_TGT2, S_SRCH_RD, S_SRCH_CMP, S_INC_RD, S_INC, S_RSP, S_HOLD
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      take;

   assign take       = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_INIT:     begin cmd.clr_step = 1'b1; cmd.scan_inc = 1'b1; end
         S_IDLE:     cmd.load = take;
         S_DISPATCH: begin
            cmd.scan_clr  = 1'b1;
            cmd.tbl_write = (sts.op == OP_WRITE);
         end
         S_CLEAR:    begin cmd.clr_step = 1'b1; cmd.scan_inc = 1'b1; end
         S_DEC_RD:   cmd.dec_rd = 1'b1;
         S_DEC:      cmd.dec_old = 1'b1;
         S_ACC_RD:   begin
            cmd.acc_rd   = 1'b1;
            cmd.scan_inc = 1'b1;
         end
         S_ACC_LAST: cmd.acc_add = 1'b1;
         S_TGT:      cmd.tgt_mul = 1'b1;
         S_TGT2:     begin cmd.tgt_add = 1'b1; cmd.scan_clr = 1'b1; end
         S_SRCH_RD:  cmd.srch_rd = 1'b1;
         S_SRCH_CMP: begin cmd.srch_cmp = 1'b1; cmd.scan_inc = 1'b1; end
         S_INC_RD:   cmd.inc_rd = 1'b1;
         S_INC:      cmd.inc_pick = 1'b1;
         S_RSP:      cmd.rsp_load = 1'b1;
         S_HOLD:     ;
         default:    ;
      endcase
   end

   // State and registered response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_INIT:     if (sts.scan_end) state_ff <= S_IDLE;
            S_IDLE:     if (take) state_ff <= S_DISPATCH;
            S_DISPATCH: begin
               case (sts.op)
                  OP_CLEAR:    state_ff <= S_CLEAR;
                  OP_COUNT:    state_ff <= S_INC_RD;
                  OP_RESAMPLE: state_ff <= S_DEC_RD;
                  default:     state_ff <= S_RSP;
               endcase
            end
            S_CLEAR:    if (sts.scan_end) state_ff <= S_RSP;
            S_DEC_RD:   state_ff <= S_DEC;
            S_DEC:      state_ff <= S_ACC_RD;
            S_ACC_RD:   state_ff <= S_ACC_LAST;
            S_ACC_LAST: state_ff <= sts.scan_done ? S_TGT : S_ACC_RD;
            S_TGT:      state_ff <= S_TGT2;
            S_TGT2:     state_ff <= S_SRCH_RD;
            S_SRCH_RD:  state_ff <= S_SRCH_CMP;
            S_SRCH_CMP: state_ff <= sts.scan_last ? S_INC_RD : S_SRCH_RD;
            S_INC_RD:   state_ff <= S_INC;
            S_INC:      state_ff <= S_RSP;
            S_RSP:      begin
               state_ff     <= S_HOLD;
               rsp_valid_ff <= 1'b1;
            end
            S_HOLD:     if (rsp_tready) begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b0;
            end
            default:    state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ rtl/core/lda_topic_gibbs_resampler.sv @@
// Top level of the collapsed Gibbs topic resampler.
// One item at a time; req_tready is high only while idle. A table write is
// stored at dispatch; a count reads and bumps the topic count; a clear zeroes
// all built topic counts, one per cycle, whatever num_topics says; a resample
// runs through dispatch, a read and a decrement of the old count, a product-sum
// pass over the K active topics (table and count read, then multiply-accumulate,
// for each topic), the target product split into halves, a search over the
// running sums, a read and a bump of the picked count, and the load of the
// result. The result then waits for the rsp transfer, and the block returns to
// idle before the next item is taken. After reset the counts are cleared by a
// pass over all built topics with req_tready low. Status of a count or resample
// is taken from the count before increment; the response register holds the
// result until the rsp transfer.
module lda_topic_gibbs_resampler import lda_pkg::*; #(
   parameter int TOPICS_MAX = TOPICS_MAX_DEF,
   parameter int WORDS_MAX  = WORDS_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[1:0], word[13:2], topic[19:14], prob_value[35:20], uniform[51:36]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // new_topic[5:0], status[7:6]
   output logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   cmd_type             cmd;
   sts_type             sts;
   logic [NT_W-1:0]     num_topics_ff;
   logic [ALPHA_W-1:0]  alpha_ff;
   logic [TOPIC_W-1:0]  out_topic;
   logic [STATUS_W-1:0] out_status;

   // Configuration registers; writes are taken any time.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         num_topics_ff <= NT_W'(64);
         alpha_ff      <= ALPHA_W'(256);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NUM_TOPICS: num_topics_ff <= csr_wdata[NT_W-1:0];
            CSR_ALPHA:      alpha_ff      <= csr_wdata;
            default:        ;
         endcase
      end
   end

   lda_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .cmd, .sts
   );

   lda_dpath #(.TOPICS_MAX(TOPICS_MAX), .WORDS_MAX(WORDS_MAX)) u_dpath (
      .clock, .reset, .cmd, .sts,
      .in_op(req_tdata[1:0]), .in_word(req_tdata[13:2]),
      .in_topic(req_tdata[19:14]), .in_prob(req_tdata[35:20]),
      .in_uniform(req_tdata[51:36]),
      .num_topics(num_topics_ff), .alpha(alpha_ff),
      .out_topic, .out_status
   );

   assign rsp_tdata = {out_status, out_topic};
endmodule

@@ rtl/core/lda_chk.sv @@
// Port checker for the resampler, bound to the top level.
`include "lda_topic_gibbs_resampler_defines.svh"
module lda_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   `LDA_ASSERT_IMPL(a_no_req_while_rsp, clock, reset, rsp_tvalid, !req_tready)
   `LDA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   `LDA_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))
   `LDA_ASSERT_IMPL(a_status_code, clock, reset, rsp_tvalid, rsp_tdata[7:6] != 2'd3)
endmodule

bind lda_topic_gibbs_resampler lda_chk u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

@@ test/testbench.sv @@
// Testbench for the collapsed Gibbs topic resampler: directed and random checks.
`timescale 1ns / 100ps
module testbench;
   import lda_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   lda_topic_gibbs_resampler dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // Expected result of one transfer.
   typedef struct packed {
      logic [TOPIC_W-1:0] topic;
      status_type         status;
   } sample_result_type;

   // Predictor state, mirrors the block's counts, table and registers.
   logic [PROB_W-1:0]  prob_mem [0:WORDS_MAX_DEF*TOPICS_MAX_DEF-1];
   logic [CNT_W-1:0]   topic_counts [0:TOPICS_MAX_DEF-1];
   logic [NT_W-1:0]    k_reg;
   logic [ALPHA_W-1:0] alpha_reg;

   sample_result_type pending_results[$];
   int error_count;
   int sent_items;
   int checked_results;
   int resample_count;
   int idle_cycles;
   int rsp_hold_cycles;
   bit rsp_stall_on;

   // Words 0..3 are fully written for all topics before any resample.
   localparam int LIVE_WORDS = 4;

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("mismatch on %s: got %0d expected %0d (result %0d)",
               what, got, want, checked_results);
   endtask

   function automatic int active_k();
      if (k_reg == 0) return 1;
      if (k_reg > TOPICS_MAX_DEF) return TOPICS_MAX_DEF;
      return k_reg;
   endfunction

   // Computes the outcome of one item and updates the predicted state.
   function automatic sample_result_type predict_sample(input op_type op,
         input logic [WORD_W-1:0] word, input logic [TOPIC_W-1:0] topic,
         input logic [PROB_W-1:0] prob, input logic [UNI_W-1:0] uniform);
      sample_result_type r;
      logic [45:0] sums [0:TOPICS_MAX_DEF-1];
      logic [45:0] total;
      logic [63:0] target;
      int pick;
      bit underflow;
      r.topic = topic;
      r.status = ST_OK;
      case (op)
         OP_WRITE: begin
            prob_mem[word*TOPICS_MAX_DEF + topic] = prob;
         end
         OP_CLEAR: begin
            foreach (topic_counts[i]) topic_counts[i] = '0;
         end
         OP_COUNT: begin
            if (topic_counts[topic] == COUNT_MAX) r.status = ST_SATURATED;
            else topic_counts[topic]++;
         end
         default: begin
            underflow = (topic_counts[topic] == 0);
            if (!underflow) topic_counts[topic]--;
            total = '0;
            for (int k = 0; k < active_k(); k++) begin
               total += ({34'd0, topic_counts[k]} << 8) * 0 + 46'(({38'd0, topic_counts[k]} << 8)
                        + alpha_reg) * prob_mem[word*TOPICS_MAX_DEF + k];
               sums[k] = total;
            end
            target = (64'(uniform) * 64'(total)) >> 16;
            pick = 0;
            for (int k = active_k() - 1; k >= 0; k--)
               if (64'(sums[k]) >= target) pick = k;
            if (underflow) r.status = ST_UNDERFLOW;
            if (topic_counts[pick] == COUNT_MAX) begin
               if (!underflow) r.status = ST_SATURATED;
            end else begin
               topic_counts[pick]++;
            end
            r.topic = pick[TOPIC_W-1:0];
         end
      endcase
      return r;
   endfunction

   // Random gap: mostly none or short, a few long.
   function automatic int random_gap();
      int sel = $urandom_range(0, 99);
      if (sel < 50) return 0;
      if (sel < 93) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Sends one item; the prediction is queued at the accepting edge.
   task automatic send_item(input op_type op, input logic [WORD_W-1:0] word,
         input logic [TOPIC_W-1:0] topic, input logic [PROB_W-1:0] prob,
         input logic [UNI_W-1:0] uniform, input bit allow_gap = 1'b1);
      int gap;
      gap = allow_gap ? random_gap() : 0;
      repeat (gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, uniform, prob, topic, word, op};
      do @(posedge clock); while (!req_tready);
      pending_results.insert(pending_results.size(),
                             predict_sample(op, word, topic, prob, uniform));
      sent_items++;
      if (op == OP_RESAMPLE) resample_count++;
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Register write, only while the block is idle.
   task automatic write_csr(input logic index, input logic [15:0] value);
      wait_drained();
      repeat (4 * TOPICS_MAX_DEF + 16) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_NUM_TOPICS) k_reg = value[NT_W-1:0];
      else alpha_reg = value;
   endtask

   // Result checker with random receive stalls.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata, 0);
         end else begin
            sample_result_type want;
            want = pending_results.pop_front();
            if (rsp_tdata[5:0] !== want.topic)
               report_mismatch("new_topic", rsp_tdata[5:0], want.topic);
            if (rsp_tdata[7:6] !== want.status)
               report_mismatch("status", rsp_tdata[7:6], want.status);
            checked_results++;
         end
      end
      // Stall pattern: mostly ready, stalls mostly short and a few long.
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else if (rsp_stall_on) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_hold_cycles <= random_gap();
      end
   end

   // Watchdog on cycles with no transfer at all.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Fill live words for all topics: word 0 with zeros, word 1 with all ones, the rest with random probabilities.
   task automatic test_table_fill();
      for (int w = 0; w < LIVE_WORDS; w++)
         for (int t = 0; t < TOPICS_MAX_DEF; t++)
            send_item(OP_WRITE, 12'(w), 6'(t), (w == 0) ? 16'd0 : (w == 1 ? 16'hFFFF :
                      16'($urandom())), 16'd0, 1'b0);
      // A far word too, with wrap-range bits set.
      send_item(OP_WRITE, 12'hFFF, 6'h3F, 16'hFFFF, 16'd0);
   endtask

   task automatic test_directed();
      send_item(OP_CLEAR, 12'hFFF, 6'h3F, 16'hFFFF, 16'hFFFF);
      // Underflow and zero-total cases on word 0 (all-zero row).
      send_item(OP_RESAMPLE, 12'd0, 6'd5, 16'd0, 16'hFFFF);
      send_item(OP_RESAMPLE, 12'd1, 6'h3F, 16'd0, 16'd0);
      send_item(OP_RESAMPLE, 12'd1, 6'd0, 16'd0, 16'hFFFF);
      send_item(OP_COUNT, 12'hABC, 6'h3F, 16'h1234, 16'h5678);
      send_item(OP_RESAMPLE, 12'd2, 6'h3F, 16'd0, 16'h8000);
      send_item(OP_RESAMPLE, 12'd0, 6'd0, 16'd0, 16'd0);   // zero row, counted topic
      send_item(OP_RESAMPLE, 12'd0, 6'd7, 16'd0, 16'd0);   // underflow on an empty topic
      send_item(OP_RESAMPLE, 12'd3, 6'd0, 16'd0, 16'd1);
      send_item(OP_CLEAR, 12'd0, 6'd0, 16'd0, 16'd0);
   endtask

   task automatic test_settings(input int phase);
      logic [NT_W-1:0]    k_set [0:5] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd17};
      logic [ALPHA_W-1:0] a_set [0:5] = '{16'd0, 16'hFFFF, 16'd256, 16'd1, 16'h8000, 16'd37};
      write_csr(CSR_NUM_TOPICS, 16'(k_set[phase]) | 16'(phase == 3 ? 16'hFF80 : 0));
      write_csr(CSR_ALPHA, a_set[phase]);
   endtask

   task automatic test_random(input int items);
      op_type op;
      for (int i = 0; i < items; i++) begin
         case ($urandom_range(0, 19))
            0: op = OP_CLEAR;
            1, 2: op = OP_WRITE;
            3, 4, 5, 6, 7, 8: op = OP_COUNT;
            default: op = OP_RESAMPLE;
         endcase
         // Writes keep hitting live words, so every resample reads a known row.
         send_item(op, (op == OP_RESAMPLE || op == OP_WRITE) ?
                   12'($urandom_range(0, LIVE_WORDS - 1)) : 12'($urandom()),
                   6'($urandom()), 16'($urandom()), 16'($urandom()));
         if (i == items / 2) wait_drained();   // sender holds off until drained
      end
   endtask

   initial begin
      k_reg = 7'd64;
      alpha_reg = 16'd256;
      foreach (topic_counts[i]) topic_counts[i] = '0;
      rsp_stall_on = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_table_fill();
      test_directed();
      for (int phase = 0; phase < 6; phase++) begin
         test_settings(phase);
         test_random(phase == 1 ? 210 : 195);
      end
      wait_drained();
      repeat (50) @(posedge clock);
      $display("Covered %0d items, %0d resamples, %0d results checked, six settings.",
               sent_items, resample_count, checked_results);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/lda_pkg.sv
rtl/core/lda_dpath.sv
rtl/core/lda_ctrl.sv
rtl/core/lda_topic_gibbs_resampler.sv
rtl/core/lda_chk.sv
test/testbench.sv
